// ===== rtl/lbi_pkg.sv =====
// Package for the ladder bytecode interpreter: payload structs, command codes,
// opcodes, sequencer states and the opcode length table. No dependencies.
package lbi_pkg;

	localparam int unsigned PROGRAM_DEPTH_DEF  = 1024;
	localparam int unsigned VARIABLE_COUNT_DEF = 256;

	typedef enum logic [2:0] {
		CMD_LOAD  = 3'd0,
		CMD_ARM   = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_SCAN  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_ARMED = 2'd1,
		ST_BAD_OP   = 2'd2,
		ST_OVERRUN  = 2'd3
	} status_t;

	localparam logic [7:0] OP_SET   = 8'd1;
	localparam logic [7:0] OP_CLR   = 8'd2;
	localparam logic [7:0] OP_CPY   = 8'd3;
	localparam logic [7:0] OP_LIT   = 8'd4;
	localparam logic [7:0] OP_MOV   = 8'd5;
	localparam logic [7:0] OP_INC   = 8'd6;
	localparam logic [7:0] OP_ADD   = 8'd7;
	localparam logic [7:0] OP_SUB   = 8'd8;
	localparam logic [7:0] OP_MUL   = 8'd9;
	localparam logic [7:0] OP_DIV   = 8'd10;
	localparam logic [7:0] OP_ADC   = 8'd11;
	localparam logic [7:0] OP_PWM   = 8'd12;
	localparam logic [7:0] OP_IFNB  = 8'd50;
	localparam logic [7:0] OP_IFB   = 8'd51;
	localparam logic [7:0] OP_IFLT  = 8'd52;
	localparam logic [7:0] OP_IFEQ  = 8'd53;
	localparam logic [7:0] OP_IFGT  = 8'd54;
	localparam logic [7:0] OP_ELSE  = 8'd160;
	localparam logic [7:0] OP_END   = 8'd255;

	typedef struct packed {
		logic [2:0]         command;
		logic [9:0]         address;
		logic [7:0]         program_byte;
		logic signed [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] read_value;
		logic [1:0]         status;
		logic [9:0]         fault_pc;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_FETCH, S_FWAIT, S_DECODE, S_OPER, S_OWAIT,
		S_VRD_A, S_VRD_B, S_VWAIT, S_EXEC, S_DIV, S_WRITE, S_DONE
	} state_t;

	function automatic logic [2:0] op_length(input logic [7:0] op);
		case (op)
			OP_SET, OP_CLR, OP_INC, OP_ADC, OP_ELSE: op_length = 3'd2;
			OP_CPY, OP_MOV, OP_IFNB, OP_IFB:         op_length = 3'd3;
			OP_LIT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_PWM,
			OP_IFEQ, OP_IFGT:                        op_length = 3'd4;
			OP_IFLT:                                 op_length = 3'd5;
			OP_END:                                  op_length = 3'd1;
			default:                                 op_length = 3'd0;
		endcase
	endfunction

endpackage

// ===== rtl/lbi_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module lbi_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/ladder_bytecode_interpreter_core.sv =====
// Top level of the ladder bytecode interpreter: command decode, scan sequencer,
// shared ALU and iterative divider. Depends on lbi_pkg and lbi_ram.
//
// Commands are taken when start is high and busy is low; each command yields
// exactly one beat on done with the result fields, and the receiver cannot
// stall it. After reset the block clears the variable store, one entry per
// cycle, with busy high. Load, arm, write and unused codes pass through the
// fetch and done states before the beat; a read and a scan while disarmed
// pass through fetch, fetch-wait and done. A scan fetches and decodes each
// opcode (fetch, fetch-wait, decode), reads each operand byte through the
// single program RAM port (operand request, operand wait), passes through the
// variable read states with a read wait when any variable is read, then
// executes and writes back; divide adds an iterative pass through the shared
// shift-subtract unit. The end opcode or a fault goes from decode to done, so
// the scan time is set by the instructions and operand bytes the program runs.
module ladder_bytecode_interpreter_core
	import lbi_pkg::*;
#(
	parameter int unsigned PROGRAM_DEPTH  = PROGRAM_DEPTH_DEF,
	parameter int unsigned VARIABLE_COUNT = VARIABLE_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  cmd_in,
	output logic      busy,
	output logic      done,
	output out_item_t result
);
	localparam int unsigned PW = $clog2(PROGRAM_DEPTH);
	localparam int unsigned VW = $clog2(VARIABLE_COUNT);
	localparam int unsigned CW = PW + 1;

	state_t state_q, state_d;
	in_item_t cmd_q;
	logic armed_q;
	logic [CW+8:0] pc_q;
	logic [2:0] len_q, bidx_q;
	logic [7:0] op_q;
	logic [7:0] p_q [1:4];
	logic [15:0] a_q, b_q, res_q;
	logic rd_b_q, wr_en_q;
	logic [VW:0] clr_q;
	logic [4:0] dcnt_q;
	logic [15:0] quo_q, rem_q, dvs_q;
	logic neg_q, div_ok_q;
	out_item_t res_d, result_q;
	logic done_q;

	logic          p_we, v_we;
	logic [PW-1:0] p_addr;
	logic [7:0]    p_rdata;
	logic [VW-1:0] v_addr;
	logic [15:0]   v_wdata, v_rdata;

	lbi_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(cmd_q.program_byte), .rdata(p_rdata)
	);
	lbi_ram #(.WIDTH(16), .DEPTH(VARIABLE_COUNT)) u_var (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
	);

	logic [CW+8:0] byte_addr;
	logic pc_over;
	logic [7:0] vsel_a, vsel_b;
	logic needs_a, needs_b, writes;
	logic [16:0] sub_try;
	logic [31:0] mul_w;

	assign byte_addr = pc_q + CW'(0) + (CW+9)'(bidx_q);
	assign pc_over   = pc_q >= (CW+9)'(PROGRAM_DEPTH);
	assign sub_try   = {rem_q[14:0], quo_q[15]} - {1'b0, dvs_q};
	assign mul_w     = $signed(a_q) * $signed(b_q);

	always_comb begin
		vsel_a = p_q[2]; vsel_b = p_q[3];
		needs_a = 1'b0; needs_b = 1'b0; writes = 1'b0;
		case (op_q)
			OP_SET, OP_CLR, OP_LIT: writes = 1'b1;
			OP_CPY, OP_MOV: begin needs_a = 1'b1; writes = 1'b1; end
			OP_INC: begin vsel_a = p_q[1]; needs_a = 1'b1; writes = 1'b1; end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				needs_a = 1'b1; needs_b = 1'b1; writes = 1'b1;
			end
			OP_IFNB, OP_IFB, OP_IFLT: begin vsel_a = p_q[1]; needs_a = 1'b1; end
			OP_IFEQ, OP_IFGT: begin
				vsel_a = p_q[1]; vsel_b = p_q[2]; needs_a = 1'b1; needs_b = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			armed_q <= 1'b0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DONE);
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_DECODE && (pc_over || op_length(p_rdata) == 3'd0 ||
					(pc_q + (CW+9)'(op_length(p_rdata)) > (CW+9)'(PROGRAM_DEPTH)))) begin
				armed_q <= 1'b0;
			end
			if (state_q == S_IDLE && start && cmd_in.command == CMD_ARM) armed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				cmd_q <= cmd_in; pc_q <= '0; res_d <= '0;
			end
			S_FETCH: bidx_q <= '0;
			S_DECODE: begin
				op_q <= p_rdata; len_q <= op_length(p_rdata); bidx_q <= 3'd1;
				if (pc_over || op_length(p_rdata) == 3'd0 ||
						(pc_q + (CW+9)'(op_length(p_rdata)) > (CW+9)'(PROGRAM_DEPTH))) begin
					res_d.status   <= pc_over ? ST_OVERRUN :
						(op_length(p_rdata) == 3'd0 ? ST_BAD_OP : ST_OVERRUN);
					res_d.fault_pc <= pc_q[9:0];
				end
			end
			S_OWAIT: begin
				p_q[bidx_q] <= p_rdata; bidx_q <= bidx_q + 1'b1;
			end
			S_VRD_B: a_q <= v_rdata;
			S_VWAIT: begin
				if (rd_b_q) b_q <= v_rdata; else a_q <= v_rdata;
			end
			S_EXEC: begin
				wr_en_q <= writes;
				case (op_q)
					OP_SET: res_q <= 16'd1;
					OP_CLR: res_q <= 16'd0;
					OP_CPY: res_q <= {15'd0, a_q != 16'd0};
					OP_LIT: res_q <= {p_q[3], p_q[2]};
					OP_MOV: res_q <= a_q;
					OP_INC: res_q <= a_q + 16'd1;
					OP_ADD: res_q <= a_q + b_q;
					OP_SUB: res_q <= a_q - b_q;
					OP_MUL: res_q <= mul_w[15:0];
					OP_DIV: begin
						div_ok_q <= b_q != 16'd0;
						neg_q    <= a_q[15] ^ b_q[15];
						quo_q    <= a_q[15] ? -a_q : a_q;
						dvs_q    <= b_q[15] ? -b_q : b_q;
						rem_q    <= '0;
						dcnt_q   <= '0;
					end
					OP_IFNB: if (a_q == 16'd0) pc_q <= pc_q + (CW+9)'(p_q[2]);
					OP_IFB:  if (a_q != 16'd0) pc_q <= pc_q + (CW+9)'(p_q[2]);
					OP_IFLT: if (!($signed(a_q) < $signed({p_q[3], p_q[2]})))
						pc_q <= pc_q + (CW+9)'(p_q[4]);
					OP_IFEQ: if (a_q != b_q) pc_q <= pc_q + (CW+9)'(p_q[3]);
					OP_IFGT: if (!($signed(a_q) > $signed(b_q)))
						pc_q <= pc_q + (CW+9)'(p_q[3]);
					OP_ELSE: pc_q <= pc_q + (CW+9)'(p_q[1]);
					default: ;
				endcase
			end
			S_DIV: begin
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == 5'd16) begin
					res_q   <= neg_q ? -quo_q : quo_q;
					wr_en_q <= div_ok_q;
				end else if (!sub_try[16]) begin
					rem_q <= sub_try[15:0]; quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= {rem_q[14:0], quo_q[15]}; quo_q <= {quo_q[14:0], 1'b0};
				end
			end
			S_WRITE: pc_q <= pc_q + (CW+9)'(len_q);
			S_DONE: ;
			default: ;
		endcase
		if (state_q == S_VRD_A) rd_b_q <= 1'b0;
		if (state_q == S_VRD_B) rd_b_q <= 1'b1;
		if (state_q == S_FWAIT && cmd_q.command == CMD_READ) res_d.read_value <= v_rdata;
		if (state_q == S_FWAIT && cmd_q.command == CMD_SCAN && !armed_q)
			res_d.status <= ST_NOT_ARMED;
		if (state_q == S_DONE) result_q <= res_d;
	end

	always_comb begin
		state_d = state_q;
		p_we = 1'b0; v_we = 1'b0;
		p_addr = byte_addr[PW-1:0];
		v_addr = cmd_q.address[VW-1:0];
		v_wdata = cmd_q.value;
		case (state_q)
			S_CLEAR: begin
				v_we = 1'b1; v_addr = clr_q[VW-1:0]; v_wdata = '0;
				if (clr_q == (VW+1)'(VARIABLE_COUNT - 1)) state_d = S_IDLE;
			end
			S_IDLE: if (start) state_d = S_FETCH;
			S_FETCH: begin
				case (cmd_q.command)
					CMD_LOAD: begin
						p_addr = PW'(cmd_q.address);
						p_we = ({{(CW+9-10){1'b0}}, cmd_q.address} <
							(CW+9)'(PROGRAM_DEPTH));
						state_d = S_DONE;
					end
					CMD_WRITE: begin v_we = 1'b1; state_d = S_DONE; end
					CMD_READ, CMD_SCAN: state_d = S_FWAIT;
					default: state_d = S_DONE;
				endcase
			end
			S_FWAIT: state_d = (cmd_q.command == CMD_SCAN && armed_q) ? S_DECODE : S_DONE;
			S_DECODE: begin
				if (pc_over || op_length(p_rdata) == 3'd0 ||
						(pc_q + (CW+9)'(op_length(p_rdata)) > (CW+9)'(PROGRAM_DEPTH)))
					state_d = S_DONE;
				else if (p_rdata == OP_END) state_d = S_DONE;
				else state_d = (op_length(p_rdata) > 3'd1) ? S_OPER : S_VRD_A;
			end
			S_OPER: state_d = S_OWAIT;
			S_OWAIT: state_d = (bidx_q + 1'b1 == len_q) ? S_VRD_A : S_OPER;
			S_VRD_A: begin
				v_addr = vsel_a[VW-1:0];
				state_d = needs_a ? (needs_b ? S_VRD_B : S_VWAIT) : S_EXEC;
			end
			S_VRD_B: begin v_addr = vsel_b[VW-1:0]; state_d = S_VWAIT; end
			S_VWAIT: state_d = S_EXEC;
			S_EXEC: state_d = (op_q == OP_DIV) ? S_DIV : S_WRITE;
			S_DIV: if (dcnt_q == 5'd16) state_d = S_WRITE;
			S_WRITE: begin
				v_addr = p_q[1][VW-1:0]; v_wdata = res_q; v_we = wr_en_q;
				state_d = S_FETCH;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_WRITE) begin
			state_d = S_FETCH;
		end
		if (state_q == S_FETCH && cmd_q.command == CMD_SCAN && pc_q != '0) begin
			p_addr = pc_q[PW-1:0];
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;
endmodule

// ===== rtl/lbi_checker.sv =====
// Port checker for the ladder bytecode interpreter, bound to the top level.
// Depends on lbi_pkg.
module lbi_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input lbi_pkg::out_item_t  result
);
	import lbi_pkg::*;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(start && !busy)) else $error("beat too early");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double beat");
	a_ok_pc: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_OK || result.status == ST_NOT_ARMED)
		|-> result.fault_pc == '0) else $error("fault_pc without fault");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after beat");
endmodule

bind ladder_bytecode_interpreter_core lbi_checker u_lbi_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);
